// ----- src/cbd2_pkg.sv -----
// Package: pixel types, register indexes and fixed sizes of the crop box downsampler.
`timescale 1ns / 1ps

package cbd2_pkg;

  localparam int MaxWidth = 64;
  localparam int LineDepth = 32;
  localparam int PairWidth = 9;
  localparam int LineWidth = 3 * PairWidth;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth = 7;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_BOX_LEFT    = 3'd1,
    REG_BOX_TOP     = 3'd2,
    REG_BOX_RIGHT   = 3'd3,
    REG_BOX_BOTTOM  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [4:0] out_col;
    logic [4:0] out_row;
    logic       image_done;
  } reduced_t;

endpackage

// ----- src/cbd2_stream_if.sv -----
// Interface: valid/ready channel carrying one payload item per transfer.
`timescale 1ns / 1ps

interface cbd2_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/crop_box_downsample_2x2_unit.sv -----
// Top level: crop box 2x2 box-filter downsampler for a raster RGB pixel stream.
`timescale 1ns / 1ps

// Takes one pixel per clock on pixel while pixel.ready is high and gives one reduced pixel
// on reduced for every 2x2 block of pixels inside the crop box, on the odd-row odd-column
// pixel of the block. Its transfer loads the line store read of the even-row pair sums and
// the s1 registers; the final add lands in the output register when s1 advances, which
// back-pressure on reduced can hold. The line store has one write and one read port, and
// each pixel does at most one of the two, so the stream runs at one pixel per clock unless
// reduced applies back-pressure. The line store is not cleared after reset. The user must
// write registers through write_enable/write_index/write_data only while no pixel is in
// flight; the block does not enforce this. Writes take effect from the next pixel.

module crop_box_downsample_2x2_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  cbd2_stream_if.sink                          pixel,
  cbd2_stream_if.source                        reduced,
  input  logic                                 write_enable,
  input  logic [cbd2_pkg::CfgIndexWidth-1:0]   write_index,
  input  logic [cbd2_pkg::CfgDataWidth-1:0]    write_data
);

  localparam int AddrWidth = $clog2(cbd2_pkg::LineDepth);
  localparam int PW = cbd2_pkg::PairWidth;

  logic [6:0] frame_width;
  logic [5:0] box_left;
  logic [5:0] box_top;
  logic [6:0] box_right;
  logic [6:0] box_bottom;

  logic [5:0]  column_pos;
  logic [5:0]  row_pos;
  logic [23:0] held_pixel;

  logic          s1_valid;
  logic [PW-1:0] s1_red;
  logic [PW-1:0] s1_green;
  logic [PW-1:0] s1_blue;
  logic [4:0]    s1_col;
  logic [4:0]    s1_row;
  logic          s1_done;

  logic                 out_valid;
  cbd2_pkg::reduced_t   out_data;

  logic          accept;
  logic          s1_advance;
  logic [5:0]    col;
  logic [5:0]    row;
  logic [5:0]    dx;
  logic [5:0]    dy;
  logic [6:0]    span_w;
  logic [6:0]    span_h;
  logic [5:0]    half_w;
  logic [5:0]    half_h;
  logic          in_box;
  logic [PW-1:0] pair_red;
  logic [PW-1:0] pair_green;
  logic [PW-1:0] pair_blue;
  logic          line_we;
  logic          line_re;
  logic [cbd2_pkg::LineWidth-1:0] line_rdata;
  logic [6:0]    fw_eff;
  logic [6:0]    col_inc;
  logic [5:0]    column_pos_next;
  logic [5:0]    row_pos_next;
  logic [PW:0]   sum_red;
  logic [PW:0]   sum_green;
  logic [PW:0]   sum_blue;

  assign s1_advance = !out_valid || reduced.ready;
  assign pixel.ready = !s1_valid || s1_advance;
  assign accept = pixel.valid && pixel.ready;

  always_comb begin
    col = pixel.data.frame_start ? 6'd0 : column_pos;
    row = pixel.data.frame_start ? 6'd0 : row_pos;
    dx = col - box_left;
    dy = row - box_top;
    span_w = (box_right > {1'b0, box_left}) ? box_right - {1'b0, box_left} : 7'd0;
    span_h = (box_bottom > {1'b0, box_top}) ? box_bottom - {1'b0, box_top} : 7'd0;
    half_w = span_w[6:1];
    half_h = span_h[6:1];
    in_box = (col >= box_left) && (row >= box_top)
          && ({1'b0, dx} < {half_w, 1'b0}) && ({1'b0, dy} < {half_h, 1'b0});
    pair_red   = {1'b0, held_pixel[23:16]} + {1'b0, pixel.data.in_red};
    pair_green = {1'b0, held_pixel[15:8]} + {1'b0, pixel.data.in_green};
    pair_blue  = {1'b0, held_pixel[7:0]} + {1'b0, pixel.data.in_blue};
    line_we = accept && in_box && dx[0] && !dy[0];
    line_re = accept && in_box && dx[0] && dy[0];

    if (frame_width == 7'd0) begin
      fw_eff = 7'd1;
    end else if (frame_width > 7'(cbd2_pkg::MaxWidth)) begin
      fw_eff = 7'(cbd2_pkg::MaxWidth);
    end else begin
      fw_eff = frame_width;
    end
    col_inc = {1'b0, col} + 7'd1;
    if (col_inc >= fw_eff) begin
      column_pos_next = 6'd0;
      row_pos_next = row + 6'd1;
    end else begin
      column_pos_next = col_inc[5:0];
      row_pos_next = row;
    end

    sum_red   = {1'b0, s1_red} + {1'b0, line_rdata[3*PW-1:2*PW]};
    sum_green = {1'b0, s1_green} + {1'b0, line_rdata[2*PW-1:PW]};
    sum_blue  = {1'b0, s1_blue} + {1'b0, line_rdata[PW-1:0]};
  end

  cbd2_ram #(
    .WIDTH(cbd2_pkg::LineWidth),
    .DEPTH(cbd2_pkg::LineDepth)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (dx[AddrWidth:1]),
    .wdata ({pair_red, pair_green, pair_blue}),
    .re    (line_re),
    .raddr (dx[AddrWidth:1]),
    .rdata (line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 7'd16;
      box_left    <= 6'd0;
      box_top     <= 6'd0;
      box_right   <= 7'd16;
      box_bottom  <= 7'd16;
      column_pos  <= 6'd0;
      row_pos     <= 6'd0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (write_enable) begin
        unique case (write_index)
          cbd2_pkg::REG_FRAME_WIDTH: frame_width <= write_data;
          cbd2_pkg::REG_BOX_LEFT:    box_left    <= write_data[5:0];
          cbd2_pkg::REG_BOX_TOP:     box_top     <= write_data[5:0];
          cbd2_pkg::REG_BOX_RIGHT:   box_right   <= write_data;
          cbd2_pkg::REG_BOX_BOTTOM:  box_bottom  <= write_data;
          default: ;
        endcase
      end
      if (accept) begin
        column_pos <= column_pos_next;
        row_pos    <= row_pos_next;
      end
      if (pixel.ready) begin
        s1_valid <= line_re;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_box && !dx[0]) begin
      held_pixel <= {pixel.data.in_red, pixel.data.in_green, pixel.data.in_blue};
    end
    if (line_re) begin
      s1_red   <= pair_red;
      s1_green <= pair_green;
      s1_blue  <= pair_blue;
      s1_col   <= dx[5:1];
      s1_row   <= dy[5:1];
      s1_done  <= ({1'b0, dx[5:1]} == half_w - 6'd1) && ({1'b0, dy[5:1]} == half_h - 6'd1);
    end
    if (s1_valid && s1_advance) begin
      out_data.out_red    <= sum_red[PW:2];
      out_data.out_green  <= sum_green[PW:2];
      out_data.out_blue   <= sum_blue[PW:2];
      out_data.out_col    <= s1_col;
      out_data.out_row    <= s1_row;
      out_data.image_done <= s1_done;
    end
  end

  assign reduced.valid = out_valid;
  assign reduced.data = out_data;

endmodule

// ----- src/cbd2_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cbd2_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
